[rtl/core/isr_pkg.sv]
// ----------------------------------------------------------------------------
// isr_pkg
// Shared types and constants for the bit-serial integer square root block.
// ----------------------------------------------------------------------------
package isr_pkg;

    localparam int RADICAND_W = 32;
    localparam int ROOT_W     = 16;
    localparam int LEFTOVER_W = 17;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_HOLD = 3'b100
    } isr_state_t;

    // Control from the sequencer to the datapath and the output register.
    typedef struct packed {
        logic load;
        logic step;
        logic capture;
    } isr_ctrl_t;

endpackage

[rtl/core/isr_ctrl.sv]
// ----------------------------------------------------------------------------
// isr_ctrl
// Sequencer: takes a transaction, runs one step per root bit, hands over.
// ----------------------------------------------------------------------------
module isr_ctrl #(
    parameter int PAIRS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              out_free,
    output isr_pkg::isr_ctrl_t ctrl
);
    import isr_pkg::*;

    localparam int CNT_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(PAIRS - 1);

    isr_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             last;

    assign last = (count_reg == LAST);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        in_ready     = 1'b0;
        ctrl.load    = 1'b0;
        ctrl.step    = 1'b0;
        ctrl.capture = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    count_next = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                ctrl.step = 1'b1;
                if (last)
                begin
                    // The final step is written straight into the output
                    // register when it has room.
                    if (out_free)
                    begin
                        ctrl.capture = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

endmodule

[rtl/core/isr_dp.sv]
// ----------------------------------------------------------------------------
// isr_dp
// Datapath: radicand shift register feeding two bits per step into a
// restoring compare-subtract on the partial remainder.
// ----------------------------------------------------------------------------
module isr_dp #(
    parameter int RADICAND_BITS = 32,
    parameter int PAIRS         = 16
) (
    input  logic                                clk,
    input  logic [isr_pkg::RADICAND_W-1:0]      radicand,
    input  isr_pkg::isr_ctrl_t                  ctrl,
    output logic [PAIRS-1:0]                    root_next,
    output logic [PAIRS+1:0]                    rem_next
);
    import isr_pkg::*;

    localparam int PAD_W = 2 * PAIRS;
    localparam int REM_W = PAIRS + 2;

    logic [PAD_W-1:0] rad_ext;
    logic [PAD_W-1:0] rad_reg, rad_next;
    logic [REM_W-1:0] rem_reg;
    logic [PAIRS-1:0] root_reg;
    logic [REM_W-1:0] shifted;
    logic [REM_W-1:0] trial;
    logic             fits;
    logic [PAIRS:0]   root_shift;

    // Only the low RADICAND_BITS bits take part; the rest read as zero.
    for (genvar i = 0; i < PAD_W; i++)
    begin : g_ext
        if (i < RADICAND_BITS && i < RADICAND_W)
        begin : g_bit
            assign rad_ext[i] = radicand[i];
        end
        else
        begin : g_zero
            assign rad_ext[i] = 1'b0;
        end
    end

    assign shifted    = {rem_reg[REM_W-3:0], rad_reg[PAD_W-1 -: 2]};
    assign trial      = {root_reg, 2'b01};
    assign fits       = (shifted >= trial);
    assign root_shift = {root_reg, fits};

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (ctrl.load)
        begin
            rad_next  = rad_ext;
            rem_next  = '0;
            root_next = '0;
        end
        else if (ctrl.step)
        begin
            rad_next  = rad_reg << 2;
            rem_next  = fits ? (shifted - trial) : shifted;
            root_next = root_shift[PAIRS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

endmodule

[rtl/core/integer_square_root_with_remainder.sv]
// ----------------------------------------------------------------------------
// integer_square_root_with_remainder
// Unsigned integer square root with remainder, one root bit per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_ready, radicand) takes one radicand per
//   transaction. The output channel (out_valid, out_ready, root, leftover)
//   returns floor(sqrt(radicand)) and radicand - root * root.
//   Only the low RADICAND_BITS bits of the radicand are used.
//   The root is formed by a restoring compare-subtract loop that consumes
//   two radicand bits per cycle, one step per root bit, after the cycle in
//   which the radicand is accepted. The last step is captured into the output
//   register when it is free, and in_ready returns in the same cycle as
//   out_valid rises, so a new radicand is taken only after the previous one
//   has left the loop.
//   A finished result sits in an output register; the next radicand is
//   accepted and worked on while that result waits. If the receiver still
//   stalls when the next result is ready, the loop holds it and in_ready
//   stays low until the output register is free.
//   Reset empties the output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module integer_square_root_with_remainder #(
    parameter int RADICAND_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [isr_pkg::RADICAND_W-1:0]    radicand,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [isr_pkg::ROOT_W-1:0]        root,
    output logic [isr_pkg::LEFTOVER_W-1:0]    leftover
);
    import isr_pkg::*;

    localparam int PAIRS = (RADICAND_BITS + 1) / 2;
    localparam int REM_W = PAIRS + 2;

    isr_ctrl_t               ctrl;
    logic                    out_free;
    logic                    out_valid_reg;
    logic [ROOT_W-1:0]       root_reg;
    logic [LEFTOVER_W-1:0]   leftover_reg;
    logic [PAIRS-1:0]        root_next;
    logic [REM_W-1:0]        rem_next;
    logic [ROOT_W-1:0]       root_res;
    logic [LEFTOVER_W-1:0]   leftover_res;

    assign out_free = !out_valid_reg || out_ready;

    isr_ctrl #(
        .PAIRS (PAIRS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    isr_dp #(
        .RADICAND_BITS (RADICAND_BITS),
        .PAIRS         (PAIRS)
    ) u_dp (
        .clk       (clk),
        .radicand  (radicand),
        .ctrl      (ctrl),
        .root_next (root_next),
        .rem_next  (rem_next)
    );

    // Fit the full-width results to the fixed output fields.
    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_root
        if (i < PAIRS)
        begin : g_bit
            assign root_res[i] = root_next[i];
        end
        else
        begin : g_zero
            assign root_res[i] = 1'b0;
        end
    end

    for (genvar i = 0; i < LEFTOVER_W; i++)
    begin : g_left
        if (i < REM_W)
        begin : g_bit
            assign leftover_res[i] = rem_next[i];
        end
        else
        begin : g_zero
            assign leftover_res[i] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.capture)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            root_reg     <= root_res;
            leftover_reg <= leftover_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign root      = root_reg;
    assign leftover  = leftover_reg;

endmodule

[rtl/core/isr_checker.sv]
// ----------------------------------------------------------------------------
// isr_checker
// Port-level checks for the integer square root block, bound to its top.
// ----------------------------------------------------------------------------
module isr_checker #(
    parameter int RADICAND_BITS = 32
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [isr_pkg::ROOT_W-1:0]        root,
    input logic [isr_pkg::LEFTOVER_W-1:0]    leftover
);
    import isr_pkg::*;

    // A stalled result must stay offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(root) && $stable(leftover))
        else $error("result changed while stalled");

    // The loop works on one radicand at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken while the loop is busy");

    // Without truncation of the fields the remainder never exceeds twice the root.
    if (RADICAND_BITS <= RADICAND_W)
    begin : g_bound
        a_leftover_bound: assert property (@(posedge clk) disable iff (!rst_n)
            out_valid |-> leftover <= {root, 1'b0})
            else $error("leftover exceeds twice the root");
    end

endmodule

bind integer_square_root_with_remainder isr_checker #(
    .RADICAND_BITS (RADICAND_BITS)
) u_isr_checker (.*);

[dv/isr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isr_scoreboard
// Watches both channels of the square root block, works out the root and
// leftover of every accepted radicand and compares them, in order, with the
// results that leave the block.
// ----------------------------------------------------------------------------
module isr_scoreboard #(
    parameter int RADICAND_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [isr_pkg::RADICAND_W-1:0]    radicand,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [isr_pkg::ROOT_W-1:0]        root,
    input  logic [isr_pkg::LEFTOVER_W-1:0]    leftover,
    output int                                errors,
    output int                                outstanding,
    output int                                checked
);

    import isr_pkg::*;

    typedef struct packed {
        logic [RADICAND_W-1:0] radicand;
        logic [ROOT_W-1:0]     root;
        logic [LEFTOVER_W-1:0] leftover;
    } sqrt_entry_t;

    sqrt_entry_t sqrt_expected_q[$];
    int          error_count   = 0;
    int          waiting_count = 0;
    int          checked_count = 0;

    assign errors      = error_count;
    assign outstanding = waiting_count;
    assign checked     = checked_count;

    // Restoring powers-of-four square root. The scaled root is kept shifted
    // left by the current power, so each trial value is scaled + quad.
    function automatic sqrt_entry_t sqrt_with_leftover(input logic [RADICAND_W-1:0] value);
        logic [63:0] rest;
        logic [63:0] scaled;
        logic [63:0] quad;
        logic [63:0] trial;
        logic [63:0] mask;
        sqrt_entry_t result;
        mask   = (RADICAND_BITS >= 64) ? '1 : ((64'd1 << RADICAND_BITS) - 64'd1);
        rest   = 64'(value) & mask;
        scaled = '0;
        quad   = 64'd1 << ((RADICAND_BITS - 1) & 62);
        while (quad != 64'd0) begin
            trial = scaled + quad;
            if (rest >= trial) begin
                rest   = rest - trial;
                scaled = (scaled >> 1) + quad;
            end
            else begin
                scaled = scaled >> 1;
            end
            quad = quad >> 2;
        end
        result.radicand = value;
        result.root     = scaled[ROOT_W-1:0];
        result.leftover = rest[LEFTOVER_W-1:0];
        return result;
    endfunction

    always @(posedge clk) begin
        sqrt_entry_t oldest;
        if (rst_n) begin
            // A result never leaves in the cycle its radicand arrives, so the
            // oldest expectation is taken before the new one is queued.
            if (out_valid && out_ready) begin
                if (sqrt_expected_q.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result root %0d leftover %0d",
                             $time, root, leftover);
                end
                else begin
                    oldest = sqrt_expected_q.pop_front();
                    waiting_count--;
                    checked_count++;
                    if (root !== oldest.root) begin
                        error_count++;
                        $display("%0t: root of %0d: expected %0d, actual %0d",
                                 $time, oldest.radicand, oldest.root, root);
                    end
                    if (leftover !== oldest.leftover) begin
                        error_count++;
                        $display("%0t: leftover of %0d: expected %0d, actual %0d",
                                 $time, oldest.radicand, oldest.leftover, leftover);
                    end
                end
            end
            if (in_valid && in_ready) begin
                sqrt_expected_q = {sqrt_expected_q, sqrt_with_leftover(radicand)};
                waiting_count++;
            end
        end
    end

endmodule

[dv/tb_integer_square_root_with_remainder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_square_root_with_remainder
// Drives radicands into the square root block, directed corner values first
// and then a random mix biased towards squares and their neighbours, with
// random idling on both channels and one long output stall. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_integer_square_root_with_remainder;

    import isr_pkg::*;

    localparam int RANDOM_COUNT = 800;
    localparam int CALM_COUNT   = 120;
    localparam int HOLD_AT      = 250;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 250000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [RADICAND_W-1:0] radicand;
    logic                  out_valid;
    logic                  out_ready;
    logic [ROOT_W-1:0]     root;
    logic [LEFTOVER_W-1:0] leftover;

    int errors;
    int outstanding;
    int checked;
    int cycle_count = 0;
    int sent_count  = 0;
    bit calm        = 1'b0;
    bit hold_req    = 1'b0;

    integer_square_root_with_remainder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .radicand  (radicand),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .root      (root),
        .leftover  (leftover)
    );

    isr_scoreboard i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .radicand    (radicand),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .root        (root),
        .leftover    (leftover),
        .errors      (errors),
        .outstanding (outstanding),
        .checked     (checked)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offers one radicand and returns at the falling edge after its
    // transaction, optionally dropping valid for an idle burst first.
    task automatic send_radicand(input logic [RADICAND_W-1:0] value, input int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        radicand <= value;
        do @(posedge clk); while (!in_ready);
        sent_count++;
        @(negedge clk);
    endtask

    function automatic int pick_gap();
        if (calm || $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(1, 14);
    endfunction

    // Half of the picks are squares and values one below a square, where the
    // restoring steps are decided by equality or by one unit.
    function automatic logic [RADICAND_W-1:0] random_radicand();
        logic [RADICAND_W-1:0] base;
        base = RADICAND_W'($urandom_range(0, 65535));
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return base * base;
            2:       return base * base + 2 * base;
            3:       return (base == 0) ? 32'd0 : base * base - 1;
            4:       return RADICAND_W'($urandom_range(0, 1023));
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    initial begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (!calm && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14) - 1) @(negedge clk);
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [RADICAND_W-1:0] corner_values[$];
        corner_values = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd8, 32'd15, 32'd16,
                          32'd17, 32'd24, 32'hFFFF_FFFF, 32'hFFFE_0001,
                          32'hFFFE_0000, 32'h8000_0000, 32'h4000_0000,
                          32'h3FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                          32'h0001_0000, 32'h0000_FFFF, 32'h7FFF_FFFF};
        rst_n    = 1'b0;
        in_valid = 1'b0;
        radicand = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (corner_values[i])
            send_radicand(corner_values[i], pick_gap());

        for (int n = 0; n < RANDOM_COUNT; n++) begin
            // The long output stall lets the block fill while the sender
            // keeps offering, so in_ready must drop.
            if (n == HOLD_AT)
                hold_req = 1'b1;
            if (n == RANDOM_COUNT - CALM_COUNT)
                calm = 1'b1;
            send_radicand(random_radicand(), pick_gap());
        end
        in_valid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Sent %0d radicands (corner values, squares and neighbours, random words);",
                 sent_count);
        $display("checked %0d results, including a %0d-cycle output stall.",
                 checked, HOLD_CYCLES);
        if (errors == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
